// ===== sv/sseg_pkg.sv =====
// Shared types, widths, result codes and product helpers for the segment intersection unit.
package sseg_pkg;

  localparam int CRD_W = 32;
  localparam int DIF_W = CRD_W + 1;
  localparam int PRD_W = 2 * DIF_W;
  localparam int CRS_W = PRD_W + 1;
  localparam int DOT_W = PRD_W + 2;
  localparam int SQ_W  = 2 * CRS_W;
  localparam int NUM_W = SQ_W + 3;
  localparam int EPS_W = 31;
  localparam int LO_W  = 33;
  localparam int HI_W  = CRS_W - LO_W;
  localparam int PP_W  = 2 * HI_W;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_CROSS   = 2'd1;
  localparam logic [1:0] KIND_OVERLAP = 2'd2;

  typedef logic signed [CRD_W-1:0] crd_t;
  typedef logic [2:0][CRD_W-1:0] crd3_t;
  typedef logic [2:0][DIF_W-1:0] dv_t;
  typedef logic [5:0][PRD_W-1:0] pr6_t;
  typedef logic [2:0][PRD_W-1:0] dp3_t;
  typedef logic [2:0][CRS_W-1:0] cv_t;
  typedef logic [2:0][SQ_W-1:0] sq3_t;
  typedef logic [2:0][3:0][PP_W-1:0] pp3_t;

  typedef struct packed {
    crd3_t as;
    crd3_t bs;
    dv_t   d1;
    dv_t   d2;
    logic  ok;
    logic  par;
    logic  col;
  } side_t;

  function automatic pr6_t xmul(dv_t a, dv_t b);
    pr6_t r;
    r[0] = $signed(a[1]) * $signed(b[2]);
    r[1] = $signed(a[2]) * $signed(b[1]);
    r[2] = $signed(a[2]) * $signed(b[0]);
    r[3] = $signed(a[0]) * $signed(b[2]);
    r[4] = $signed(a[0]) * $signed(b[1]);
    r[5] = $signed(a[1]) * $signed(b[0]);
    return r;
  endfunction

  function automatic cv_t xsum(pr6_t p);
    cv_t r;
    for (int i = 0; i < 3; i++) begin
      r[i] = $signed(p[2*i]) - $signed(p[2*i+1]);
    end
    return r;
  endfunction

  function automatic dp3_t dmul(dv_t a, dv_t b);
    dp3_t r;
    for (int i = 0; i < 3; i++) begin
      r[i] = $signed(a[i]) * $signed(b[i]);
    end
    return r;
  endfunction

  // wide products split into high (signed) and low (unsigned) halves
  function automatic pp3_t cpart(cv_t a, cv_t b);
    pp3_t r;
    for (int i = 0; i < 3; i++) begin
      r[i][0] = $signed(a[i][CRS_W-1:LO_W]) * $signed(b[i][CRS_W-1:LO_W]);
      r[i][1] = $signed(a[i][CRS_W-1:LO_W]) * $signed({1'b0, b[i][LO_W-1:0]});
      r[i][2] = $signed({1'b0, a[i][LO_W-1:0]}) * $signed(b[i][CRS_W-1:LO_W]);
      r[i][3] = a[i][LO_W-1:0] * b[i][LO_W-1:0];
    end
    return r;
  endfunction

  function automatic sq3_t csum(pp3_t p);
    sq3_t r;
    for (int i = 0; i < 3; i++) begin
      r[i] = (SQ_W'($signed(p[i][0])) << (2 * LO_W))
           + ((SQ_W'($signed(p[i][1])) + SQ_W'($signed(p[i][2]))) << LO_W)
           + SQ_W'(p[i][3]);
    end
    return r;
  endfunction

endpackage

// ===== sv/sseg_if.sv =====
// Request and result channel interfaces of the segment intersection unit.
interface sseg_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] a_start_x, a_start_y, a_start_z;
  logic signed [31:0] a_end_x, a_end_y, a_end_z;
  logic signed [31:0] b_start_x, b_start_y, b_start_z;
  logic signed [31:0] b_end_x, b_end_y, b_end_z;
  modport source (output valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
                  b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z, input ready);
  modport sink (input valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
                b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z, output ready);
endinterface

interface sseg_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic [1:0] hit_kind;
  logic signed [31:0] point_x, point_y, point_z;
  modport source (output valid, hit, hit_kind, point_x, point_y, point_z, input ready);
  modport sink (input valid, hit, hit_kind, point_x, point_y, point_z, output ready);
endinterface

// ===== sv/sseg_div.sv =====
// Pipelined restoring divider: two numerators over one positive denominator, saturated Q2 quotients.
module sseg_div #(
  parameter int F  = 16,
  parameter int NW = 137,
  parameter int SW = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic signed [NW-1:0] num_a_i,
  input  logic signed [NW-1:0] num_b_i,
  input  logic [NW-1:0]        den_i,
  input  logic [SW-1:0]        side_i,
  output logic                 vld_o,
  output logic signed [F+2:0]  qa_o,
  output logic signed [F+2:0]  qb_o,
  output logic [SW-1:0]        side_o
);
  localparam int QW = F + 3;
  localparam int RW = NW + F + 3;
  localparam int ST = F + 3;

  logic          vld_r  [0:ST];
  logic [RW-1:0] rema_r [0:ST];
  logic [RW-1:0] remb_r [0:ST];
  logic [QW-1:0] qa_r   [0:ST];
  logic [QW-1:0] qb_r   [0:ST];
  logic          nega_r [0:ST];
  logic          negb_r [0:ST];
  logic [NW-1:0] den_r  [0:ST];
  logic [SW-1:0] side_r [0:ST];

  logic [NW-1:0] maga, magb;
  assign maga = num_a_i[NW-1] ? NW'(-num_a_i) : num_a_i;
  assign magb = num_b_i[NW-1] ? NW'(-num_b_i) : num_b_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
    if (en) begin
      rema_r[0] <= RW'(maga) << F;
      remb_r[0] <= RW'(magb) << F;
      qa_r[0]   <= '0;
      qb_r[0]   <= '0;
      nega_r[0] <= num_a_i[NW-1];
      negb_r[0] <= num_b_i[NW-1];
      den_r[0]  <= den_i;
      side_r[0] <= side_i;
    end
  end

  for (genvar i = 1; i <= ST; i++) begin : g_bit
    localparam int K = ST - i;
    logic [RW-1:0] dsh;
    logic ge_a, ge_b;
    assign dsh  = RW'(den_r[i-1]) << K;
    assign ge_a = rema_r[i-1] >= dsh;
    assign ge_b = remb_r[i-1] >= dsh;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_r[i-1];
      end
      if (en) begin
        rema_r[i] <= ge_a ? rema_r[i-1] - dsh : rema_r[i-1];
        remb_r[i] <= ge_b ? remb_r[i-1] - dsh : remb_r[i-1];
        qa_r[i]   <= qa_r[i-1] | (ge_a ? QW'(1) << K : QW'(0));
        qb_r[i]   <= qb_r[i-1] | (ge_b ? QW'(1) << K : QW'(0));
        nega_r[i] <= nega_r[i-1];
        negb_r[i] <= negb_r[i-1];
        den_r[i]  <= den_r[i-1];
        side_r[i] <= side_r[i-1];
      end
    end
  end

  logic [QW-1:0] lima, limb, qca, qcb;
  assign lima = (QW'(1) << (F + 1)) - (nega_r[ST] ? QW'(0) : QW'(1));
  assign limb = (QW'(1) << (F + 1)) - (negb_r[ST] ? QW'(0) : QW'(1));
  assign qca  = (qa_r[ST] > lima) ? lima : qa_r[ST];
  assign qcb  = (qb_r[ST] > limb) ? limb : qb_r[ST];
  assign qa_o = nega_r[ST] ? $signed(QW'(-qca)) : $signed(qca);
  assign qb_o = negb_r[ST] ? $signed(QW'(-qcb)) : $signed(qcb);
  assign vld_o  = vld_r[ST];
  assign side_o = side_r[ST];

endmodule

// ===== sv/segment_segment_intersection_3d_unit.sv =====
// Top level: pipelined 3D segment/segment intersection test with Q2 parameter division.
//
//   port       dir  role
//   in_if      in   segment pair request, valid/ready
//   out_if     out  hit, hit_kind, point, valid/ready
//   cfg_*      in   eps_sq write, no read-back
//
// One request per cycle while out_if is ready or the result stage is empty; the divider
// resolves one quotient bit per stage. Reset clears every stage valid and sets eps_sq to 1.
// A stalled result freezes the whole pipe; nothing is dropped or repeated.
module segment_segment_intersection_3d_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  sseg_in_if.sink                   in_if,
  sseg_out_if.source                out_if,
  input  logic                      cfg_we,
  input  logic [sseg_pkg::EPS_W-1:0] cfg_wdata
);
  import sseg_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int QW  = F + 3;
  localparam int PW  = DIF_W + QW;
  localparam int EW  = PW - F + 1;
  localparam int DFW = DIF_W;
  localparam int DSW = 2 * DFW;
  localparam int DDW = DSW + 2;

  logic [EPS_W-1:0] eps_r;
  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v45_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_W'(1);
    end else if (cfg_we) begin
      eps_r <= cfg_wdata;
    end
  end

  assign en          = !v10_r || out_if.ready;
  assign in_if.ready = en;

  // stage 1: differences
  crd3_t as_in, ae_in, bs_in, be_in;
  dv_t d1_nxt, d2_nxt, s_nxt, e_nxt;
  assign as_in = {in_if.a_start_z, in_if.a_start_y, in_if.a_start_x};
  assign ae_in = {in_if.a_end_z, in_if.a_end_y, in_if.a_end_x};
  assign bs_in = {in_if.b_start_z, in_if.b_start_y, in_if.b_start_x};
  assign be_in = {in_if.b_end_z, in_if.b_end_y, in_if.b_end_x};
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1_nxt[i] = DIF_W'($signed(ae_in[i])) - DIF_W'($signed(as_in[i]));
      d2_nxt[i] = DIF_W'($signed(be_in[i])) - DIF_W'($signed(bs_in[i]));
      s_nxt[i]  = DIF_W'($signed(bs_in[i])) - DIF_W'($signed(as_in[i]));
      e_nxt[i]  = DIF_W'($signed(be_in[i])) - DIF_W'($signed(as_in[i]));
    end
  end

  side_t sd1_r, sd2_r, sd3_r, sd4_r, sd45_r, sd5_r;
  dv_t s1_r, e1_r, s2e_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sd1_r.as  <= as_in;
      sd1_r.bs  <= bs_in;
      sd1_r.d1  <= d1_nxt;
      sd1_r.d2  <= d2_nxt;
      sd1_r.ok  <= (d1_nxt != '0) && (d2_nxt != '0);
      sd1_r.par <= 1'b0;
      sd1_r.col <= 1'b0;
      s1_r      <= s_nxt;
      e1_r      <= e_nxt;
    end
  end

  // stage 2: first products
  pr6_t pc2_r, pcs2_r, pcw2_r;
  dp3_t ps2_r, pe2_r, pd2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sd2_r  <= sd1_r;
      s2e_r  <= s1_r;
      pc2_r  <= xmul(sd1_r.d1, sd1_r.d2);
      pcs2_r <= xmul(s1_r, sd1_r.d1);
      pcw2_r <= xmul(s1_r, sd1_r.d2);
      ps2_r  <= dmul(s1_r, sd1_r.d1);
      pe2_r  <= dmul(e1_r, sd1_r.d1);
      pd2_r  <= dmul(sd1_r.d1, sd1_r.d1);
    end
  end

  // stage 3: cross vectors and first dots
  cv_t c3_r, cs3_r, cw3_r;
  logic signed [DOT_W-1:0] ds3_r, de3_r, dd3_r, ds4_r, de4_r, dd4_r;
  logic signed [DOT_W-1:0] ds45_r, de45_r, dd45_r, ds5_r, de5_r, dq5_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sd3_r  <= sd2_r;
      c3_r   <= xsum(pc2_r);
      cs3_r  <= xsum(pcs2_r);
      cw3_r  <= xsum(pcw2_r);
      ds3_r  <= $signed(ps2_r[0]) + $signed(ps2_r[1]) + $signed(ps2_r[2]);
      de3_r  <= $signed(pe2_r[0]) + $signed(pe2_r[1]) + $signed(pe2_r[2]);
      dd3_r  <= $signed(pd2_r[0]) + $signed(pd2_r[1]) + $signed(pd2_r[2]);
    end
  end

  // stage 4: second products, half-width partials
  pp3_t pcsq4_r, pcssq4_r, pn14_r, pn24_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sd4_r    <= sd3_r;
      pcsq4_r  <= cpart(c3_r, c3_r);
      pcssq4_r <= cpart(cs3_r, cs3_r);
      pn14_r   <= cpart(cw3_r, c3_r);
      pn24_r   <= cpart(cs3_r, c3_r);
      ds4_r    <= ds3_r;
      de4_r    <= de3_r;
      dd4_r    <= dd3_r;
    end
  end

  // stage 4b: partials combined
  sq3_t csq45_r, cssq45_r, n145_r, n245_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sd45_r   <= sd4_r;
      csq45_r  <= csum(pcsq4_r);
      cssq45_r <= csum(pcssq4_r);
      n145_r   <= csum(pn14_r);
      n245_r   <= csum(pn24_r);
      ds45_r   <= ds4_r;
      de45_r   <= de4_r;
      dd45_r   <= dd4_r;
    end
  end

  // stage 5: sums, parallel and collinear tests
  logic signed [NUM_W-1:0] csq5_r, cssq5_r, n15_r, n25_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sd5_r   <= sd45_r;
      csq5_r  <= $signed(csq45_r[0]) + $signed(csq45_r[1]) + $signed(csq45_r[2]);
      cssq5_r <= $signed(cssq45_r[0]) + $signed(cssq45_r[1]) + $signed(cssq45_r[2]);
      n15_r   <= $signed(n145_r[0]) + $signed(n145_r[1]) + $signed(n145_r[2]);
      n25_r   <= $signed(n245_r[0]) + $signed(n245_r[1]) + $signed(n245_r[2]);
      ds5_r   <= ds45_r;
      de5_r   <= de45_r;
      dq5_r   <= dd45_r;
    end
  end

  logic signed [NUM_W-1:0] eps_w, num_a, num_b;
  logic [NUM_W-1:0] den;
  logic par5, col5;
  side_t sd5x, sdd;
  assign eps_w = $signed({{(NUM_W-EPS_W){1'b0}}, eps_r});
  assign par5  = (csq5_r == '0) || ((csq5_r >>> (3 * F)) < eps_w);
  assign col5  = (cssq5_r >>> (3 * F)) < eps_w;
  assign num_a = par5 ? NUM_W'(ds5_r) : n15_r;
  assign num_b = par5 ? NUM_W'(de5_r) : n25_r;
  assign den   = par5 ? NUM_W'(dq5_r) : csq5_r;
  always_comb begin
    sd5x     = sd5_r;
    sd5x.par = par5;
    sd5x.col = col5;
  end

  logic vd;
  logic signed [QW-1:0] qa, qb;
  logic [$bits(side_t)-1:0] sdd_bits;
  sseg_div #(.F(F), .NW(NUM_W), .SW($bits(side_t))) u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(v5_r),
    .num_a_i(num_a), .num_b_i(num_b), .den_i(den), .side_i(sd5x),
    .vld_o(vd), .qa_o(qa), .qb_o(qb), .side_o(sdd_bits)
  );
  assign sdd = side_t'(sdd_bits);

  // stage 6: parameter checks, overlap midpoint
  localparam logic signed [QW-1:0] ONE = QW'(1) << F;
  logic signed [QW-1:0] ulo, uhi, clo, chi, mid, m1_nxt, m2_nxt;
  logic [1:0] kind_nxt;
  always_comb begin
    ulo = (qa > qb) ? qb : qa;
    uhi = (qa > qb) ? qa : qb;
    clo = (ulo < 0) ? '0 : ulo;
    chi = (uhi > ONE) ? ONE : uhi;
    mid = QW'((QW+1)'(clo) + (QW+1)'(chi) >>> 1);
    kind_nxt = KIND_NONE;
    m1_nxt = qa;
    m2_nxt = qb;
    if (sdd.ok) begin
      if (sdd.par) begin
        m1_nxt = mid;
        if (sdd.col && uhi >= 0 && ulo <= ONE) kind_nxt = KIND_OVERLAP;
      end else if (qa >= 0 && qa <= ONE && qb >= 0 && qb <= ONE) begin
        kind_nxt = KIND_CROSS;
      end
    end
  end

  side_t sd6_r, sd7_r;
  logic [1:0] k6_r, k7_r, k8_r, k9_r;
  logic signed [QW-1:0] m16_r, m26_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sd6_r <= sdd;
      k6_r  <= kind_nxt;
      m16_r <= m1_nxt;
      m26_r <= m2_nxt;
    end
  end

  // stage 7: direction times parameter
  logic [2:0][PW-1:0] pr17_r, pr27_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sd7_r <= sd6_r;
      k7_r  <= k6_r;
      for (int i = 0; i < 3; i++) begin
        pr17_r[i] <= $signed(sd6_r.d1[i]) * m16_r;
        pr27_r[i] <= $signed(sd6_r.d2[i]) * m26_r;
      end
    end
  end

  // stage 8: points on A and B; the gap only matters for a crossing, where both fit 32 bits
  logic [2:0][EW-1:0] p8_r, p9_r;
  logic [2:0][DFW-1:0] df8_r;
  logic [2:0][EW-1:0] p_nxt, q_nxt;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_nxt[i] = EW'($signed(sd7_r.as[i])) + EW'($signed(pr17_r[i]) >>> F);
      q_nxt[i] = EW'($signed(sd7_r.bs[i])) + EW'($signed(pr27_r[i]) >>> F);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      k8_r <= k7_r;
      p8_r <= p_nxt;
      for (int i = 0; i < 3; i++) begin
        df8_r[i] <= DFW'($signed(p_nxt[i])) - DFW'($signed(q_nxt[i]));
      end
    end
  end

  // stage 9: squared gaps
  logic [2:0][DSW-1:0] sq9_r;
  always_ff @(posedge clk) begin
    if (en) begin
      k9_r <= k8_r;
      p9_r <= p8_r;
      for (int i = 0; i < 3; i++) begin
        sq9_r[i] <= $signed(df8_r[i]) * $signed(df8_r[i]);
      end
    end
  end

  // stage 10: agreement test, result register
  logic signed [DDW-1:0] gap;
  logic close;
  logic [1:0] kind_fin;
  assign gap   = DDW'(sq9_r[0]) + DDW'(sq9_r[1]) + DDW'(sq9_r[2]);
  assign close = (gap >>> F) < $signed(DDW'(eps_r));
  assign kind_fin = (k9_r == KIND_CROSS && !close) ? KIND_NONE : k9_r;

  logic hit_r;
  logic [1:0] kind_r;
  logic [2:0][CRD_W-1:0] pt_r;
  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= kind_fin != KIND_NONE;
      kind_r <= kind_fin;
      for (int i = 0; i < 3; i++) begin
        pt_r[i] <= (kind_fin != KIND_NONE) ? p9_r[i][CRD_W-1:0] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v45_r <= 1'b0; v5_r <= 1'b0;
      v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0; v9_r <= 1'b0; v10_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_if.valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v45_r <= v4_r;
      v5_r <= v45_r;
      v6_r <= vd; v7_r <= v6_r; v8_r <= v7_r; v9_r <= v8_r; v10_r <= v9_r;
    end
  end

  assign out_if.valid    = v10_r;
  assign out_if.hit      = hit_r;
  assign out_if.hit_kind = kind_r;
  assign out_if.point_x  = pt_r[0];
  assign out_if.point_y  = pt_r[1];
  assign out_if.point_z  = pt_r[2];

  a_hit_kind: assert property (@(posedge clk) disable iff (!rst_n)
    v10_r |-> (hit_r == (kind_r != KIND_NONE)))
    else $error("hit disagrees with hit_kind");
  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    v10_r |-> (kind_r == KIND_NONE || kind_r == KIND_CROSS || kind_r == KIND_OVERLAP))
    else $error("bad hit_kind");
  a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (v10_r && !hit_r) |-> (pt_r == '0))
    else $error("miss with non-zero point");
  a_rst: assert property (@(posedge clk) !rst_n |=> !v10_r)
    else $error("valid after reset");

endmodule

// ===== test/segment_segment_intersection_3d_unit_tb.sv =====
// Self-checking testbench for the 3D segment/segment intersection unit.
`timescale 1ns / 100ps

module segment_segment_intersection_3d_unit_tb;
  import sseg_pkg::*;

  localparam int FRAC = 16;
  localparam int DRAIN = 40;
  localparam int LIMIT = 800000;
  localparam int RAND_PER_PHASE = 240;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [31:0] c32_t;

  typedef struct {
    c32_t a0[3];
    c32_t a1[3];
    c32_t b0[3];
    c32_t b1[3];
  } seg_pair_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] kind;
    logic [31:0] px, py, pz;
  } hit_t;

  class hit_scoreboard;
    logic [EPS_W-1:0] eps_sq;
    hit_t pending[$];
    int n_checked, n_errors, n_cross, n_overlap;

    function new();
      eps_sq = 1;
    endfunction

    function wide_t dotw(input wide_t a[3], input wide_t b[3]);
      return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function void crossw(input wide_t a[3], input wide_t b[3], output wide_t r[3]);
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function bit below(wide_t sq, int sh);
      wide_t e;
      e = wide_t'(eps_sq);
      return (sq >>> sh) < e;
    endfunction

    // Q2 quotient, truncated toward zero and saturated
    function longint qdiv(wide_t num, wide_t den);
      bit neg;
      wide_t m, q, lim;
      neg = num < 0;
      m = neg ? -num : num;
      q = (m <<< FRAC) / den;
      lim = neg ? (wide_t'(1) <<< (FRAC + 1)) : ((wide_t'(1) <<< (FRAC + 1)) - 1);
      if (q > lim) q = lim;
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function void note(seg_pair_t r);
      longint d1[3], d2[3], p[3], q[3];
      wide_t w1[3], w2[3], ws[3], we[3], c[3], cs[3], c2[3], csq, dsq, dd;
      longint t1, t2, u1, u2, tmp, lo, hi, mid, one;
      hit_t e;
      int kind;
      kind = 0;
      one = longint'(1) <<< FRAC;
      for (int i = 0; i < 3; i++) begin
        d1[i] = longint'(r.a1[i]) - longint'(r.a0[i]);
        d2[i] = longint'(r.b1[i]) - longint'(r.b0[i]);
        w1[i] = wide_t'(d1[i]);
        w2[i] = wide_t'(d2[i]);
        ws[i] = wide_t'(longint'(r.b0[i]) - longint'(r.a0[i]));
        we[i] = wide_t'(longint'(r.b1[i]) - longint'(r.a0[i]));
        p[i] = 0;
      end
      if ((d1[0] | d1[1] | d1[2]) != 0 && (d2[0] | d2[1] | d2[2]) != 0) begin
        crossw(w1, w2, c);
        csq = dotw(c, c);
        crossw(ws, w1, cs);
        if (csq == 0 || below(csq, 3 * FRAC)) begin
          if (below(dotw(cs, cs), 3 * FRAC)) begin
            dsq = dotw(w1, w1);
            u1 = qdiv(dotw(ws, w1), dsq);
            u2 = qdiv(dotw(we, w1), dsq);
            if (u1 > u2) begin
              tmp = u1; u1 = u2; u2 = tmp;
            end
            if (u2 >= 0 && u1 <= one) begin
              lo = u1 < 0 ? 0 : u1;
              hi = u2 > one ? one : u2;
              mid = (lo + hi) >>> 1;
              for (int i = 0; i < 3; i++) p[i] = longint'(r.a0[i]) + ((d1[i] * mid) >>> FRAC);
              kind = 2;
            end
          end
        end else begin
          crossw(ws, w2, c2);
          t1 = qdiv(dotw(c2, c), csq);
          t2 = qdiv(dotw(cs, c), csq);
          if (t1 >= 0 && t1 <= one && t2 >= 0 && t2 <= one) begin
            dd = 0;
            for (int i = 0; i < 3; i++) begin
              p[i] = longint'(r.a0[i]) + ((d1[i] * t1) >>> FRAC);
              q[i] = longint'(r.b0[i]) + ((d2[i] * t2) >>> FRAC);
              dd = dd + wide_t'(p[i] - q[i]) * wide_t'(p[i] - q[i]);
            end
            if (below(dd, FRAC)) kind = 1;
          end
        end
      end
      e.hit = kind != 0;
      e.kind = kind == 1 ? KIND_CROSS : (kind == 2 ? KIND_OVERLAP : KIND_NONE);
      e.px = kind != 0 ? p[0][31:0] : '0;
      e.py = kind != 0 ? p[1][31:0] : '0;
      e.pz = kind != 0 ? p[2][31:0] : '0;
      pending.push_back(e);
    endfunction

    function void check(hit_t got);
      hit_t e;
      if (pending.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result: kind %0d", got.kind);
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (got.kind == KIND_CROSS) n_cross++;
      if (got.kind == KIND_OVERLAP) n_overlap++;
      if (got !== e) begin
        n_errors++;
        if (n_errors <= 10)
          $display("mismatch #%0d: exp hit %b kind %0d (%h %h %h) got hit %b kind %0d (%h %h %h)",
                   n_checked, e.hit, e.kind, e.px, e.py, e.pz,
                   got.hit, got.kind, got.px, got.py, got.pz);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [EPS_W-1:0] cfg_wdata;
  sseg_in_if in_ch ();
  sseg_out_if out_ch ();
  hit_scoreboard sb;
  int cycles;
  bit hold_go;
  int n_sent;

  segment_segment_intersection_3d_unit #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    seg_pair_t r;
    hit_t h;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      r.a0 = '{in_ch.a_start_x, in_ch.a_start_y, in_ch.a_start_z};
      r.a1 = '{in_ch.a_end_x, in_ch.a_end_y, in_ch.a_end_z};
      r.b0 = '{in_ch.b_start_x, in_ch.b_start_y, in_ch.b_start_z};
      r.b1 = '{in_ch.b_end_x, in_ch.b_end_y, in_ch.b_end_z};
      sb.note(r);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      h.hit = out_ch.hit;
      h.kind = out_ch.hit_kind;
      h.px = out_ch.point_x;
      h.py = out_ch.point_y;
      h.pz = out_ch.point_z;
      sb.check(h);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stalls in bursts, calm stretches, one long hold-off
  initial begin
    int mode;
    out_ch.ready = 0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 2);
      for (int k = 0; k < 100; k++) begin
        @(negedge clk);
        if (hold_go) begin
          hold_go = 0;
          out_ch.ready = 0;
          repeat (400) @(negedge clk);
        end
        if (mode == 0) out_ch.ready = 1;
        else if (mode == 1) out_ch.ready = $urandom_range(0, 3) != 0;
        else out_ch.ready = pick_gap() == 0;
      end
    end
  end

  function automatic int srnd(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic seg_pair_t make_pair(int shape);
    seg_pair_t r;
    int p[3], u[3], v[3], m, n, k, l, sh;
    sh = $urandom_range(6, 16);
    m = $urandom_range(0, 4); n = $urandom_range(0, 4);
    k = srnd(5); l = srnd(5);
    for (int i = 0; i < 3; i++) begin
      p[i] = srnd(1 << 22);
      u[i] = srnd(4) <<< sh;
      v[i] = srnd(4) <<< sh;
    end
    for (int i = 0; i < 3; i++) begin
      case (shape)
        0: begin
          r.a0[i] = $urandom; r.a1[i] = $urandom; r.b0[i] = $urandom; r.b1[i] = $urandom;
        end
        1, 2: begin
          r.a0[i] = p[i] - m * u[i]; r.a1[i] = p[i] + n * u[i];
          r.b0[i] = p[i] - n * v[i]; r.b1[i] = p[i] + m * v[i];
          if (shape == 2) r.b1[i] = p[i];
        end
        3, 4: begin
          r.a0[i] = p[i] - m * u[i]; r.a1[i] = p[i] + n * u[i];
          r.b0[i] = p[i] + k * u[i]; r.b1[i] = p[i] + l * u[i];
          if (shape == 4) begin
            r.b0[i] += v[i]; r.b1[i] += v[i];
          end
        end
        default: begin
          r.a0[i] = srnd(1 << 18); r.a1[i] = srnd(1 << 18);
          r.b0[i] = srnd(1 << 18); r.b1[i] = srnd(1 << 18);
        end
      endcase
    end
    return r;
  endfunction

  function automatic seg_pair_t pair_of(int a0x, int a0y, int a0z, int a1x, int a1y, int a1z,
                                        int b0x, int b0y, int b0z, int b1x, int b1y, int b1z);
    seg_pair_t r;
    r.a0 = '{a0x, a0y, a0z}; r.a1 = '{a1x, a1y, a1z};
    r.b0 = '{b0x, b0y, b0z}; r.b1 = '{b1x, b1y, b1z};
    return r;
  endfunction

  task automatic send_request(seg_pair_t r, int gap);
    in_ch.a_start_x = r.a0[0]; in_ch.a_start_y = r.a0[1]; in_ch.a_start_z = r.a0[2];
    in_ch.a_end_x = r.a1[0]; in_ch.a_end_y = r.a1[1]; in_ch.a_end_z = r.a1[2];
    in_ch.b_start_x = r.b0[0]; in_ch.b_start_y = r.b0[1]; in_ch.b_start_z = r.b0[2];
    in_ch.b_end_x = r.b1[0]; in_ch.b_end_y = r.b1[1]; in_ch.b_end_z = r.b1[2];
    in_ch.valid = 1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    n_sent++;
    if (gap > 0) begin
      in_ch.valid = 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_eps(logic [EPS_W-1:0] val);
    wait_drained();
    cfg_we = 1;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 0;
    sb.eps_sq = val;
  endtask

  localparam int ONE = 1 << 16;
  localparam int MAXC = 32'h7fffffff;
  localparam int MINC = 32'h80000000;

  initial begin
    seg_pair_t r;
    logic [EPS_W-1:0] eps_list[5];
    sb = new();
    cycles = 0;
    hold_go = 0;
    n_sent = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    in_ch.valid = 0;
    {in_ch.a_start_x, in_ch.a_start_y, in_ch.a_start_z} = '0;
    {in_ch.a_end_x, in_ch.a_end_y, in_ch.a_end_z} = '0;
    {in_ch.b_start_x, in_ch.b_start_y, in_ch.b_start_z} = '0;
    {in_ch.b_end_x, in_ch.b_end_y, in_ch.b_end_z} = '0;
    repeat (6) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: degenerate, crossing, touching, overlap, parallel, extremes
    send_request(pair_of(0, 0, 0, 0, 0, 0, 0, 0, 0, ONE, 0, 0), pick_gap());
    send_request(pair_of(0, 0, 0, ONE, 0, 0, 5, 5, 5, 5, 5, 5), pick_gap());
    send_request(pair_of(-ONE, 0, 0, ONE, 0, 0, 0, -ONE, 0, 0, ONE, 0), pick_gap());
    send_request(pair_of(0, 0, 0, 2*ONE, 2*ONE, 0, 0, 2*ONE, 0, 2*ONE, 0, 0), pick_gap());
    send_request(pair_of(0, 0, 0, ONE, 0, 0, ONE, 0, 0, ONE, ONE, 0), pick_gap());
    send_request(pair_of(0, 0, 0, ONE, 0, 0, 2*ONE, -ONE, 0, 2*ONE, ONE, 0), pick_gap());
    send_request(pair_of(0, 0, 0, 4*ONE, 0, 0, 2*ONE, 0, 0, 6*ONE, 0, 0), pick_gap());
    send_request(pair_of(0, 0, 0, 4*ONE, 0, 0, 6*ONE, 0, 0, -ONE, 0, 0), pick_gap());
    send_request(pair_of(0, 0, 0, 4*ONE, 0, 0, 4*ONE, 0, 0, 7*ONE, 0, 0), pick_gap());
    send_request(pair_of(0, 0, 0, 4*ONE, 0, 0, 5*ONE, 0, 0, 7*ONE, 0, 0), pick_gap());
    send_request(pair_of(0, 0, 0, 4*ONE, 0, 0, 0, ONE, 0, 4*ONE, ONE, 0), pick_gap());
    send_request(pair_of(0, 0, 0, ONE, 0, 0, -1, -ONE, 0, -1, ONE, 0), pick_gap());
    send_request(pair_of(0, 0, 0, ONE, 0, 0, ONE/2, -ONE, 1, ONE/2, ONE, -1), pick_gap());
    send_request(pair_of(MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MAXC),
                 pick_gap());
    send_request(pair_of(MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MAXC, MAXC),
                 pick_gap());
    send_request(pair_of(MAXC, 0, MINC, MINC, 0, MAXC, 0, MAXC, 0, 0, MINC, 0), pick_gap());
    send_request(pair_of(-1, -1, -1, 0, 0, 0, 0, 0, 0, -1, -1, 0), pick_gap());

    eps_list = '{31'd1, 31'd0, 31'h7fffffff, 31'h00010000, 31'($urandom_range(0, 255))};
    foreach (eps_list[ph]) begin
      write_eps(eps_list[ph]);
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        if (ph == 0 && k == 40) hold_go = 1;
        r = make_pair($urandom_range(0, 9) < 2 ? 0 : $urandom_range(1, 5));
        send_request(r, pick_gap());
      end
    end

    in_ch.valid = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    $display("%0d segment pairs sent over %0d eps_sq settings, %0d results checked",
             n_sent, 5, sb.n_checked);
    $display("%0d crossings and %0d collinear overlaps seen, %0d mismatches",
             sb.n_cross, sb.n_overlap, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
